>>> design/pdfs_pkg.sv
`timescale 1ns / 1ps

package pdfs_pkg;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_PUSH  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_TICKS_PER_UNIT  = 2'd0;
  localparam logic [1:0] REG_SYNC_HIGH_UNITS = 2'd1;
  localparam logic [1:0] REG_SYNC_LOW_UNITS  = 2'd2;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;

  // register reset values
  localparam logic [15:0] TICKS_PER_UNIT_RESET  = 16'd50;
  localparam logic [7:0]  SYNC_HIGH_UNITS_RESET = 8'd20;
  localparam logic [7:0]  SYNC_LOW_UNITS_RESET  = 8'd10;

  localparam int TICK_COUNT_WIDTH_DEFAULT = 16;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_PRE_H   = 4'd1,
    PH_PRE_L   = 4'd2,
    PH_SYNC_H  = 4'd3,
    PH_SYNC_L  = 4'd4,
    PH_BIT_H   = 4'd5,
    PH_BIT_L   = 4'd6,
    PH_WAIT    = 4'd7,
    PH_CLOSE_H = 4'd8,
    PH_CLOSE_L = 4'd9
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic need_byte;
    logic accepted;
    logic underrun;
    logic frame_done;
  } result_t;

  typedef struct packed {
    logic [15:0] ticks_per_unit;
    logic [7:0]  sync_high_units;
    logic [7:0]  sync_low_units;
  } cfg_t;

endpackage

>>> design/rf_pulse_distance_frame_sender.sv
`timescale 1ns / 1ps

// Pulse-distance frame sender: each transfer on the item channel is a tick, a
// frame start (byte_value is the length) or a data byte push, and produces
// exactly one result transfer describing the line after that item. One item is
// taken every clock cycle while the result side is not stalled; each item passes
// through the input register and then the result register, and a stalled
// result side holds new items off only once both registers are full.
// Configuration registers (0 ticks_per_unit, 1 sync_high_units, 2
// sync_low_units) are written through cfg_write_en/cfg_index/cfg_data; the user
// must write them only while the sender is idle, as the block does not enforce it.
module rf_pulse_distance_frame_sender import pdfs_pkg::*; #(
  parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  item_t                      item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output result_t                    result,
  input  logic                       cfg_write_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  cfg_t    cfg;
  logic    stage_valid;
  item_t   stage_item;
  logic    advance;
  result_t core_result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_unit  <= TICKS_PER_UNIT_RESET;
      cfg.sync_high_units <= SYNC_HIGH_UNITS_RESET;
      cfg.sync_low_units  <= SYNC_LOW_UNITS_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_TICKS_PER_UNIT:  cfg.ticks_per_unit  <= cfg_data[15:0];
        REG_SYNC_HIGH_UNITS: cfg.sync_high_units <= cfg_data[7:0];
        REG_SYNC_LOW_UNITS:  cfg.sync_low_units  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // stage moves on when the result register is free or being drained
  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_item <= item;
    end
  end

  pdfs_core #(
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (stage_item),
    .cfg    (cfg),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

`ifndef SYNTH
  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !advance)
    else $error("result overwritten while stalled");

  // input register only drops an item by passing it on
  a_stage_pass: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid)
    else $error("staged item lost");

  // every advance produces a visible result
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("advance without result");
`endif

endmodule

>>> design/pdfs_core.sv
`timescale 1ns / 1ps

module pdfs_core import pdfs_pkg::*; #(
  parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int CW = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;

  phase_t                      phase, phase_next;
  logic [7:0]                  shift_byte, shift_byte_next;
  logic [2:0]                  bit_index, bit_index_next;
  logic                        sending_complement, sending_complement_next;
  logic [7:0]                  bytes_left, bytes_left_next;
  logic [7:0]                  holding_byte, holding_byte_next;
  logic                        holding_full, holding_full_next;
  logic [TICK_COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [7:0]                  unit_count, unit_count_next;

  logic [CW-1:0] tpu_ext;
  logic [CW-1:0] cmax_ext;
  logic [CW-1:0] tpu_sat;
  logic [CW:0]   tc;
  logic          tc_hit;
  logic [8:0]    uc;
  logic [7:0]    seg_units;
  logic          unit_hit;
  logic          cur_bit;
  logic          do_fetch;
  logic          acc;
  logic          under;
  logic          done;

  // unit length in ticks, zero acts as one, saturated to the counter range
  assign tpu_ext  = CW'((cfg.ticks_per_unit == 16'd0) ? 16'd1 : cfg.ticks_per_unit);
  assign cmax_ext = CW'({TICK_COUNT_WIDTH{1'b1}});
  assign tpu_sat  = (tpu_ext > cmax_ext) ? cmax_ext : tpu_ext;
  assign tc       = {1'b0, CW'(tick_count)} + {{CW{1'b0}}, 1'b1};
  assign tc_hit   = (tc >= {1'b0, tpu_sat});

  // current bit and segment length in units
  assign cur_bit = shift_byte[bit_index] ^ sending_complement;

  always_comb begin
    unique case (phase)
      PH_SYNC_H: seg_units = (cfg.sync_high_units == 8'd0) ? 8'd1 : cfg.sync_high_units;
      PH_SYNC_L: seg_units = (cfg.sync_low_units == 8'd0) ? 8'd1 : cfg.sync_low_units;
      PH_BIT_L:  seg_units = cur_bit ? 8'd2 : 8'd1;
      default:   seg_units = 8'd1;
    endcase
  end

  assign uc       = {1'b0, unit_count} + 9'd1;
  assign unit_hit = (uc >= {1'b0, seg_units});

  // next state
  always_comb begin
    phase_next              = phase;
    shift_byte_next         = shift_byte;
    bit_index_next          = bit_index;
    sending_complement_next = sending_complement;
    bytes_left_next         = bytes_left;
    holding_byte_next       = holding_byte;
    holding_full_next       = holding_full;
    tick_count_next         = tick_count;
    unit_count_next         = unit_count;
    do_fetch                = 1'b0;
    acc                     = 1'b0;
    under                   = 1'b0;
    done                    = 1'b0;

    unique case (item.command)
      CMD_TICK: begin
        if (phase == PH_WAIT) begin
          do_fetch = 1'b1;
        end else if (phase != PH_IDLE) begin
          if (tc_hit) begin
            tick_count_next = '0;
            if (unit_hit) begin
              unit_count_next = '0;
              // end of segment
              unique case (phase)
                PH_PRE_H:   phase_next = PH_PRE_L;
                PH_PRE_L:   phase_next = PH_SYNC_H;
                PH_SYNC_H:  phase_next = PH_SYNC_L;
                PH_SYNC_L:  phase_next = PH_BIT_H;
                PH_BIT_H:   phase_next = PH_BIT_L;
                PH_BIT_L: begin
                  if (bit_index != 3'd7) begin
                    bit_index_next = bit_index + 3'd1;
                    phase_next     = PH_BIT_H;
                  end else if (!sending_complement) begin
                    bit_index_next          = 3'd0;
                    sending_complement_next = 1'b1;
                    phase_next              = PH_BIT_H;
                  end else if (bytes_left == 8'd0) begin
                    phase_next = PH_CLOSE_H;
                  end else begin
                    do_fetch = 1'b1;
                  end
                end
                PH_CLOSE_H: phase_next = PH_CLOSE_L;
                PH_CLOSE_L: begin
                  phase_next = PH_IDLE;
                  done       = 1'b1;
                end
                default:    phase_next = PH_IDLE;
              endcase
            end else begin
              unit_count_next = uc[7:0];
            end
          end else begin
            tick_count_next = tc[TICK_COUNT_WIDTH-1:0];
          end
        end
      end
      CMD_START: begin
        if (phase == PH_IDLE) begin
          shift_byte_next         = item.byte_value;
          bit_index_next          = 3'd0;
          sending_complement_next = 1'b0;
          bytes_left_next         = item.byte_value;
          phase_next              = PH_PRE_H;
          tick_count_next         = '0;
          unit_count_next         = '0;
          acc                     = 1'b1;
        end
      end
      CMD_PUSH: begin
        if (!holding_full) begin
          holding_byte_next = item.byte_value;
          holding_full_next = 1'b1;
          acc               = 1'b1;
        end
      end
      default: ;
    endcase

    // data byte due: load from the holding register or wait
    if (do_fetch) begin
      tick_count_next = '0;
      unit_count_next = '0;
      if (holding_full) begin
        shift_byte_next         = holding_byte;
        holding_full_next       = 1'b0;
        bytes_left_next         = bytes_left - 8'd1;
        bit_index_next          = 3'd0;
        sending_complement_next = 1'b0;
        phase_next              = PH_BIT_H;
      end else begin
        phase_next = PH_WAIT;
        under      = 1'b1;
      end
    end
  end

  // result fields from the state after the item
  always_comb begin
    result.line_level = (phase_next == PH_PRE_H) || (phase_next == PH_SYNC_H) ||
                        (phase_next == PH_BIT_H) || (phase_next == PH_CLOSE_H);
    result.busy_res   = (phase_next != PH_IDLE);
    result.need_byte  = (phase_next != PH_IDLE) && !holding_full_next &&
                        (bytes_left_next != 8'd0);
    result.accepted   = acc;
    result.underrun   = under;
    result.frame_done = done;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      shift_byte         <= '0;
      bit_index          <= '0;
      sending_complement <= 1'b0;
      bytes_left         <= '0;
      holding_full       <= 1'b0;
      tick_count         <= '0;
      unit_count         <= '0;
    end else if (step) begin
      phase              <= phase_next;
      shift_byte         <= shift_byte_next;
      bit_index          <= bit_index_next;
      sending_complement <= sending_complement_next;
      bytes_left         <= bytes_left_next;
      holding_full       <= holding_full_next;
      tick_count         <= tick_count_next;
      unit_count         <= unit_count_next;
    end
  end

  // holding register data
  always_ff @(posedge clk) begin
    if (step) begin
      holding_byte <= holding_byte_next;
    end
  end

`ifndef SYNTH
  // a frame that finishes leaves the sender idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && result.frame_done |=> phase == PH_IDLE)
    else $error("frame_done without return to idle");

  // an underrun parks the sender waiting for a byte
  a_under_wait: assert property (@(posedge clk) disable iff (rst)
    step && result.underrun |=> phase == PH_WAIT && !holding_full)
    else $error("underrun without wait");

  // a taken push fills the holding register
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    step && item.command == CMD_PUSH && result.accepted |=> holding_full)
    else $error("push taken but holding register empty");

  // line only driven high inside a frame
  a_level_busy: assert property (@(posedge clk) disable iff (rst)
    result.line_level |-> result.busy_res)
    else $error("line high while idle");
`endif

endmodule

>>> sim/rf_pulse_distance_frame_sender_tb.sv
`timescale 1ns / 1ps

module rf_pulse_distance_frame_sender_tb;
  import pdfs_pkg::*;

  localparam int TCW = TICK_COUNT_WIDTH_DEFAULT;
  localparam int CYCLE_LIMIT = 500000;
  // command value the block treats as no operation
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_write_en = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  // predicted sender state and timing registers
  logic [15:0] tpu_q = TICKS_PER_UNIT_RESET;
  logic [7:0] sh_q = SYNC_HIGH_UNITS_RESET;
  logic [7:0] sl_q = SYNC_LOW_UNITS_RESET;
  phase_t ph = PH_IDLE;
  logic [7:0] shift_q = '0;
  logic [2:0] bit_q = '0;
  logic compl_q = 1'b0;
  logic [7:0] left_q = '0;
  logic [7:0] hold_q = '0;
  logic hold_full_q = 1'b0;
  longint unsigned tick_q = 0;
  logic [7:0] unit_q = '0;

  result_t line_results_due[$];
  result_t oldest_due;
  int mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int cycle_count = 0;

  rf_pulse_distance_frame_sender #(
    .TICK_COUNT_WIDTH(TCW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void enter_phase(phase_t p);
    ph = p;
    tick_q = 0;
    unit_q = '0;
  endfunction

  // data byte due: take it from the holding register or wait, 1 on underrun
  function automatic logic load_byte();
    if (hold_full_q) begin
      shift_q = hold_q;
      hold_full_q = 1'b0;
      left_q = left_q - 8'd1;
      bit_q = '0;
      compl_q = 1'b0;
      enter_phase(PH_BIT_H);
      return 1'b0;
    end
    enter_phase(PH_WAIT);
    return 1'b1;
  endfunction

  // line state after one item
  function automatic result_t advance_sender(item_t it);
    result_t r;
    logic acc;
    logic under;
    logic done;
    longint unsigned cmax;
    longint unsigned tpu_eff;
    longint unsigned tc;
    int unsigned seg;
    int unsigned uc;
    acc = 1'b0;
    under = 1'b0;
    done = 1'b0;
    cmax = (longint'(1) << TCW) - 1;
    case (it.command)
      CMD_TICK: begin
        if (ph == PH_WAIT) begin
          under = load_byte();
        end else if (ph != PH_IDLE) begin
          tpu_eff = (tpu_q == 0) ? 1 : tpu_q;
          if (tpu_eff > cmax) tpu_eff = cmax;
          tc = tick_q + 1;
          if (tc < tpu_eff) begin
            tick_q = tc;
          end else begin
            tick_q = 0;
            uc = unit_q + 1;
            // segment length in units, zero registers act as one
            case (ph)
              PH_SYNC_H: seg = (sh_q == 0) ? 1 : sh_q;
              PH_SYNC_L: seg = (sl_q == 0) ? 1 : sl_q;
              PH_BIT_L: seg = 1 + (shift_q[bit_q] ^ compl_q);
              default: seg = 1;
            endcase
            if (uc < seg) begin
              unit_q = uc[7:0];
            end else begin
              unit_q = '0;
              case (ph)
                PH_PRE_H: enter_phase(PH_PRE_L);
                PH_PRE_L: enter_phase(PH_SYNC_H);
                PH_SYNC_H: enter_phase(PH_SYNC_L);
                PH_SYNC_L: enter_phase(PH_BIT_H);
                PH_BIT_H: enter_phase(PH_BIT_L);
                PH_BIT_L: begin
                  // next bit, then the complement, then next byte or closing pulse
                  if (bit_q != 3'd7) begin
                    bit_q = bit_q + 3'd1;
                    enter_phase(PH_BIT_H);
                  end else if (!compl_q) begin
                    bit_q = '0;
                    compl_q = 1'b1;
                    enter_phase(PH_BIT_H);
                  end else if (left_q == 0) begin
                    enter_phase(PH_CLOSE_H);
                  end else begin
                    under = load_byte();
                  end
                end
                PH_CLOSE_H: enter_phase(PH_CLOSE_L);
                PH_CLOSE_L: begin
                  enter_phase(PH_IDLE);
                  done = 1'b1;
                end
                default: enter_phase(PH_IDLE);
              endcase
            end
          end
        end
      end
      CMD_START: begin
        if (ph == PH_IDLE) begin
          shift_q = it.byte_value;
          bit_q = '0;
          compl_q = 1'b0;
          left_q = it.byte_value;
          enter_phase(PH_PRE_H);
          acc = 1'b1;
        end
      end
      CMD_PUSH: begin
        if (!hold_full_q) begin
          hold_q = it.byte_value;
          hold_full_q = 1'b1;
          acc = 1'b1;
        end
      end
      default: ;
    endcase
    r.line_level = (ph == PH_PRE_H) || (ph == PH_SYNC_H) || (ph == PH_BIT_H) ||
                   (ph == PH_CLOSE_H);
    r.busy_res = (ph != PH_IDLE);
    r.need_byte = (ph != PH_IDLE) && !hold_full_q && (left_q != 0);
    r.accepted = acc;
    r.underrun = under;
    r.frame_done = done;
    return r;
  endfunction

  function automatic void check_field(string name, logic want, logic got);
    if (want !== got) begin
      $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // result side: random stall and compare each transfer with the oldest prediction
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && result_valid && result_ready) begin
      if (line_results_due.size() == 0) begin
        $display("%0t: result expected none actual %b", $time, result);
        mismatch_count++;
      end else begin
        oldest_due = line_results_due.pop_front();
        check_field("line_level", oldest_due.line_level, result.line_level);
        check_field("busy_res", oldest_due.busy_res, result.busy_res);
        check_field("need_byte", oldest_due.need_byte, result.need_byte);
        check_field("accepted", oldest_due.accepted, result.accepted);
        check_field("underrun", oldest_due.underrun, result.underrun);
        check_field("frame_done", oldest_due.frame_done, result.frame_done);
      end
    end
  end

  // one item transfer, with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] val);
    item_t it;
    it.command = cmd;
    it.byte_value = val;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    line_results_due.push_back(advance_sender(it));
    items_sent++;
  endtask

  // stop sending and let every predicted result arrive
  task automatic wait_line_quiet();
    item_valid <= 1'b0;
    @(posedge clk);
    while (line_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timing(input logic [15:0] tpu_w, input logic [15:0] sh_w,
                            input logic [15:0] sl_w);
    wait_line_quiet();
    cfg_write_en <= 1'b1;
    cfg_index <= REG_TICKS_PER_UNIT;
    cfg_data <= tpu_w;
    @(posedge clk);
    cfg_index <= REG_SYNC_HIGH_UNITS;
    cfg_data <= sh_w;
    @(posedge clk);
    cfg_index <= REG_SYNC_LOW_UNITS;
    cfg_data <= sl_w;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    tpu_q = tpu_w;
    sh_q = sh_w[7:0];
    sl_q = sl_w[7:0];
  endtask

  // tick until the frame ends; when starving, bytes come only after underruns
  task automatic run_frame_out(input bit starve);
    int unsigned waited = 0;
    while (ph != PH_IDLE) begin
      if (!hold_full_q && left_q != 0 && (!starve || (ph == PH_WAIT && waited >= 2))) begin
        send_item(CMD_PUSH, 8'($urandom_range(255)));
        waited = 0;
      end else begin
        if (ph == PH_WAIT) waited++;
        send_item(CMD_TICK, 8'($urandom_range(255)));
      end
    end
  endtask

  // unused command, start while busy (a tick while idle), or a push that may find the register full
  task automatic send_noise();
    case ($urandom_range(2))
      0: send_item(CMD_UNUSED, 8'($urandom_range(255)));
      1: begin
        if (ph != PH_IDLE) send_item(CMD_START, 8'($urandom_range(255)));
        else send_item(CMD_TICK, 8'($urandom_range(255)));
      end
      default: send_item(CMD_PUSH, 8'($urandom_range(255)));
    endcase
  endtask

  task automatic test_idle_commands();
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_UNUSED, 8'hA5);
    send_item(CMD_PUSH, 8'h00);
    send_item(CMD_PUSH, 8'hFF);
    send_item(CMD_TICK, 8'hFF);
  endtask

  // reset timing through the first preamble units, data byte pushed right after
  // the start; the rest of the frame runs at the shortest unit
  task automatic test_default_frame();
    send_item(CMD_START, 8'h01);
    send_item(CMD_START, 8'hFF);
    send_item(CMD_PUSH, 8'h5A);
    repeat (110) send_item(CMD_TICK, 8'($urandom_range(255)));
    set_timing(16'd1, 16'd1, 16'd1);
    run_frame_out(1'b0);
  endtask

  task automatic test_underrun();
    set_timing(16'd1, 16'd1, 16'd1);
    send_item(CMD_START, 8'h02);
    run_frame_out(1'b1);
  endtask

  // zero registers act as one; next frame starts right after frame_done
  task automatic test_zero_timing();
    set_timing(16'd0, 16'd0, 16'd0);
    send_item(CMD_PUSH, 8'hFF);
    send_item(CMD_START, 8'h03);
    run_frame_out(1'b0);
    send_item(CMD_START, 8'h00);
    run_frame_out(1'b0);
  endtask

  // longest sync segments, upper data bits ignored
  task automatic test_long_sync();
    idle_pct = 24;
    stall_pct = 24;
    set_timing(16'd1, 16'hFFFF, 16'hFFFF);
    send_item(CMD_START, 8'h00);
    run_frame_out(1'b0);
  endtask

  task automatic test_random();
    int unsigned stop_at;
    int unsigned push_pct;
    int unsigned r;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 47; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 47; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      stop_at = items_sent + 100;
      while (items_sent < stop_at) begin
        if ($urandom_range(99) < 35) begin
          set_timing(($urandom_range(99) < 60) ? 16'd1 : 16'($urandom_range(3)),
                     16'(($urandom_range(255) << 8) | $urandom_range(4)),
                     16'(($urandom_range(255) << 8) | $urandom_range(4)));
        end
        // slow byte supply in some frames to force underruns
        push_pct = ($urandom_range(99) < 25) ? 3 : 40;
        while ($urandom_range(99) < 25) send_noise();
        send_item(CMD_START, ($urandom_range(99) < 90) ? 8'($urandom_range(2)) :
                             8'($urandom_range(6, 3)));
        while (ph != PH_IDLE) begin
          r = $urandom_range(99);
          if (r < 4) send_noise();
          else if (!hold_full_q && left_q != 0 && r < 4 + push_pct)
            send_item(CMD_PUSH, 8'($urandom_range(255)));
          else send_item(CMD_TICK, 8'($urandom_range(255)));
        end
      end
    end
  endtask

  // widest unit; the frame is left running at the end of the run
  task automatic test_long_unit();
    idle_pct = 0;
    stall_pct = 0;
    set_timing(16'hFFFF, 16'h00FF, 16'hFF00);
    send_item(CMD_START, 8'h00);
    repeat (100) send_item(CMD_TICK, 8'($urandom_range(255)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_idle_commands();
    test_default_frame();
    test_underrun();
    test_zero_timing();
    test_long_sync();
    test_random();
    test_long_unit();
    wait_line_quiet();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
